[rtl/prm_pkg.sv]
package prm_pkg;

	localparam int MAX_ASSETS_DEF = 32;

	// input opcodes
	localparam logic [1:0] OP_ASSET   = 2'd0;
	localparam logic [1:0] OP_CORR    = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	// configuration register indexes
	localparam logic CFG_ASSET_COUNT = 1'b0;
	localparam logic CFG_RISK_FREE   = 1'b1;

	localparam int VAR_W = 48;
	localparam int VOL_W = 24;

	typedef struct packed {
		logic               start;
		logic [VAR_W-1:0]   variance;
		logic signed [32:0] excess;
	} prm_math_req_t;

	typedef struct packed {
		logic               done;
		logic [VOL_W-1:0]   vol;
		logic signed [31:0] sharpe;
		logic               undef;
		logic               sat;
	} prm_math_rsp_t;

endpackage

[rtl/prm_in_if.sv]
interface prm_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [4:0]         asset_index;
	logic [4:0]         peer_index;
	logic [15:0]        weight;
	logic [31:0]        price;
	logic signed [23:0] expected_return;
	logic [23:0]        risk;
	logic signed [15:0] correlation;

	modport source (output valid, opcode, asset_index, peer_index, weight, price,
		expected_return, risk, correlation, input ready);
	modport sink (input valid, opcode, asset_index, peer_index, weight, price,
		expected_return, risk, correlation, output ready);
endinterface

[rtl/prm_out_if.sv]
interface prm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] portfolio_return;
	logic [39:0]        weighted_price;
	logic [47:0]        variance;
	logic [23:0]        volatility;
	logic signed [31:0] sharpe_ratio;
	logic               sharpe_undefined;
	logic               saturated;

	modport source (output valid, portfolio_return, weighted_price, variance, volatility,
		sharpe_ratio, sharpe_undefined, saturated, input ready);
	modport sink (input valid, portfolio_return, weighted_price, variance, volatility,
		sharpe_ratio, sharpe_undefined, saturated, output ready);
endinterface

[rtl/portfolio_risk_metrics.sv]
// Portfolio risk engine. Opcode 0 writes one asset record and opcode 1 one
// correlation entry, each with no result word. Opcode 2 walks the first
// n = min(asset_count, MAX_ASSETS) assets and returns one word:
// weighted return, weighted price, variance, volatility and Sharpe ratio.
// A compute word makes n*n reads of the correlation memory, one entry a cycle,
// drains the multiply-accumulate pipeline, then takes the square root and the
// division in a shared iterative unit.
// Asset and correlation memories are not cleared; read only entries loaded.
module portfolio_risk_metrics #(
	parameter int MAX_ASSETS = prm_pkg::MAX_ASSETS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	prm_in_if.sink      in_ch,
	prm_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);
	import prm_pkg::*;

	localparam int IW  = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
	localparam int AW  = $clog2(MAX_ASSETS * MAX_ASSETS);
	localparam int CW  = $clog2(MAX_ASSETS + 1);
	localparam int RSW = 41 + IW + 1;
	localparam int WPW = 48 + IW + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_MATH  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	localparam logic signed [64:0] ACC_LIM = 65'sh0_4000_0000_0000_0000;

	logic [95:0] asset_mem [MAX_ASSETS];
	logic [15:0] corr_mem  [MAX_ASSETS * MAX_ASSETS];

	logic [5:0]         asset_count_q;
	logic signed [23:0] rfr_q;
	logic [2:0]         state_q;
	logic [IW-1:0]      i_q, j_q, last_q;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               diag_s1, diag_s2, diag_s3;
	logic               row0_s1, row0_s2;
	logic [95:0]        rec_a_s1, rec_b_s1;
	logic [15:0]        c_s1, c_s2, c_s3;
	logic [23:0]        ai_s2, aj_s2;
	logic signed [40:0] wr_s2;
	logic [47:0]        wp_s2;
	logic [47:0]        prod_s3;
	logic signed [49:0] term_s4;

	logic signed [RSW-1:0] ret_sum_q;
	logic [WPW-1:0]        wp_sum_q;
	logic signed [63:0]    acc_q;

	logic signed [31:0] ret_q;
	logic [39:0]        wp_q;
	logic [47:0]        var_q;
	logic               sat_q;

	logic               out_valid_q;
	logic signed [31:0] o_ret_q, o_sharpe_q;
	logic [39:0]        o_wp_q;
	logic [47:0]        o_var_q;
	logic [23:0]        o_vol_q;
	logic               o_undef_q, o_sat_q;

	prm_math_req_t math_req;
	prm_math_rsp_t math_rsp;

	logic            in_fire, ld_asset, ld_corr, go;
	logic [IW-1:0]   wa, wp_idx;
	logic [AW-1:0]   wr_addr, rd_addr;
	logic [CW-1:0]   n_c;
	logic            pipe_busy;
	logic            out_load;

	logic [39:0]        pa, pb;
	logic signed [64:0] cprod;
	logic signed [64:0] acc_sum;
	logic signed [RSW-1:0] ret_sh;
	logic [WPW-1:0]     wp_sh;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign ld_asset    = in_fire && in_ch.opcode == OP_ASSET
		&& int'(in_ch.asset_index) < MAX_ASSETS;
	assign ld_corr     = in_fire && in_ch.opcode == OP_CORR
		&& int'(in_ch.asset_index) < MAX_ASSETS && int'(in_ch.peer_index) < MAX_ASSETS;
	assign go          = in_fire && in_ch.opcode == OP_COMPUTE;

	assign wa      = IW'(in_ch.asset_index);
	assign wp_idx  = IW'(in_ch.peer_index);
	assign wr_addr = AW'(AW'(wa) * AW'(MAX_ASSETS) + AW'(wp_idx));
	assign rd_addr = AW'(AW'(i_q) * AW'(MAX_ASSETS) + AW'(j_q));

	assign n_c = (int'(asset_count_q) > MAX_ASSETS) ? CW'(MAX_ASSETS) : CW'(asset_count_q);
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asset_count_q <= 6'd32;
			rfr_q         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ASSET_COUNT: asset_count_q <= cfg_data[5:0];
				CFG_RISK_FREE:   rfr_q         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// memories: one write, registered reads
	always_ff @(posedge clk) begin
		if (ld_asset) begin
			asset_mem[wa] <= {in_ch.weight, in_ch.price, in_ch.expected_return, in_ch.risk};
		end
		if (ld_corr) begin
			corr_mem[wr_addr] <= in_ch.correlation;
		end
		rec_a_s1 <= asset_mem[j_q];
		rec_b_s1 <= asset_mem[i_q];
		c_s1     <= corr_mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			last_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go) begin
						i_q    <= '0;
						j_q    <= '0;
						last_q <= IW'(n_c - CW'(1));
						state_q <= (n_c == '0) ? S_DRAIN : S_WALK;
					end
				end
				S_WALK: begin
					if (j_q == last_q) begin
						j_q <= '0;
						if (i_q == last_q) begin
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q + IW'(1);
						end
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_MATH;
				S_MATH: begin
					if (math_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_WALK);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign pa = 40'(rec_a_s1[95:80]) * 40'(rec_a_s1[23:0]);
	assign pb = 40'(rec_b_s1[95:80]) * 40'(rec_b_s1[23:0]);
	assign cprod = $signed({17'd0, prod_s3}) * 65'(signed'(c_s3));

	always_ff @(posedge clk) begin
		diag_s1 <= (i_q == j_q);
		row0_s1 <= (i_q == '0);

		diag_s2 <= diag_s1;
		row0_s2 <= row0_s1;
		aj_s2   <= pa[39:16];
		ai_s2   <= pb[39:16];
		wr_s2   <= $signed({25'd0, rec_a_s1[95:80]})
			* $signed({{17{rec_a_s1[47]}}, rec_a_s1[47:24]});
		wp_s2   <= 48'(rec_a_s1[95:80]) * 48'(rec_a_s1[79:48]);
		c_s2    <= c_s1;

		diag_s3 <= diag_s2;
		prod_s3 <= 48'(ai_s2) * 48'(aj_s2);
		c_s3    <= c_s2;

		// the diagonal correlation is one
		term_s4 <= diag_s3 ? 50'(prod_s3) : 50'(cprod >>> 15);
	end

	assign acc_sum = 65'(acc_q) + 65'(term_s4);

	always_ff @(posedge clk) begin
		if (go) begin
			ret_sum_q <= '0;
			wp_sum_q  <= '0;
			acc_q     <= '0;
		end else begin
			if (v_s2 && row0_s2) begin
				ret_sum_q <= ret_sum_q + RSW'(wr_s2);
				wp_sum_q  <= wp_sum_q + WPW'(wp_s2);
			end
			if (v_s4) begin
				if (acc_sum > ACC_LIM) begin
					acc_q <= 64'(ACC_LIM);
				end else if (acc_sum < -ACC_LIM) begin
					acc_q <= 64'(-ACC_LIM);
				end else begin
					acc_q <= 64'(acc_sum);
				end
			end
		end
	end

	assign ret_sh = ret_sum_q >>> 16;
	assign wp_sh  = wp_sum_q >> 16;

	// clamp the sums once the pipeline has drained
	always_ff @(posedge clk) begin
		if (state_q == S_DRAIN && !pipe_busy) begin
			if ((&ret_sh[RSW-1:31]) || !(|ret_sh[RSW-1:31])) begin
				ret_q <= ret_sh[31:0];
			end else begin
				ret_q <= ret_sh[RSW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end
			wp_q <= (|wp_sh[WPW-1:40]) ? 40'hFF_FFFF_FFFF : wp_sh[39:0];
			if (acc_q < 0) begin
				var_q <= '0;
			end else if (|acc_q[63:48]) begin
				var_q <= 48'hFFFF_FFFF_FFFF;
			end else begin
				var_q <= acc_q[47:0];
			end
			sat_q <= !((&ret_sh[RSW-1:31]) || !(|ret_sh[RSW-1:31]))
				|| (|wp_sh[WPW-1:40]) || (|acc_q[63:48]);
		end
	end

	assign math_req.start    = (state_q == S_START);
	assign math_req.variance = var_q;
	assign math_req.excess   = 33'(ret_q) - 33'(rfr_q);

	prm_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (math_req),
		.rsp    (math_rsp)
	);

	// output register: hold the word until taken
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_ret_q    <= ret_q;
			o_wp_q     <= wp_q;
			o_var_q    <= var_q;
			o_vol_q    <= math_rsp.vol;
			o_sharpe_q <= math_rsp.sharpe;
			o_undef_q  <= math_rsp.undef;
			o_sat_q    <= sat_q || math_rsp.sat;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.portfolio_return = o_ret_q;
	assign out_ch.weighted_price   = o_wp_q;
	assign out_ch.variance         = o_var_q;
	assign out_ch.volatility       = o_vol_q;
	assign out_ch.sharpe_ratio     = o_sharpe_q;
	assign out_ch.sharpe_undefined = o_undef_q;
	assign out_ch.saturated        = o_sat_q;

endmodule

[rtl/prm_math.sv]
module prm_math (
	input  logic                   clk,
	input  logic                   arst_n,
	input  prm_pkg::prm_math_req_t req,
	output prm_pkg::prm_math_rsp_t rsp
);
	import prm_pkg::*;

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_SQRT = 2'd1;
	localparam logic [1:0] M_DIV  = 2'd2;
	localparam logic [1:0] M_DONE = 2'd3;

	logic [1:0]       mstate_q;
	logic [5:0]       cnt_q;
	logic [47:0]      x_q;
	logic [25:0]      rem_q;
	logic [23:0]      root_q;
	logic             neg_q;
	logic [48:0]      num_q;
	logic [24:0]      drem_q;
	logic [48:0]      quo_q;
	prm_math_rsp_t    rsp_q;

	logic [27:0] sq_sh, sq_t, sq_diff;
	logic        sq_ge;
	logic [25:0] dv_sh, dv_d, dv_diff;
	logic        dv_ge;
	logic [32:0] ex_mag;

	assign sq_sh   = {rem_q, x_q[47:46]};
	assign sq_t    = {2'b00, root_q, 2'b01};
	assign sq_ge   = sq_sh >= sq_t;
	assign sq_diff = sq_sh - sq_t;

	assign dv_sh   = {drem_q, num_q[48]};
	assign dv_d    = {2'b00, root_q};
	assign dv_ge   = dv_sh >= dv_d;
	assign dv_diff = dv_sh - dv_d;

	assign ex_mag = req.excess[32] ? 33'(-req.excess) : 33'(req.excess);

	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstate_q <= M_IDLE;
			cnt_q    <= '0;
			rsp_q    <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			case (mstate_q)
				M_IDLE: begin
					if (req.start) begin
						cnt_q    <= 6'd23;
						mstate_q <= M_SQRT;
					end
				end
				M_SQRT: begin
					if (cnt_q == '0) begin
						cnt_q    <= 6'd48;
						mstate_q <= M_DIV;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				M_DIV: begin
					// zero volatility leaves the ratio undefined
					if (root_q == '0 || cnt_q == '0) begin
						mstate_q <= M_DONE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				M_DONE: begin
					rsp_q.done  <= 1'b1;
					rsp_q.vol   <= root_q;
					rsp_q.undef <= (root_q == '0);
					if (neg_q) begin
						if (quo_q > 49'h0_8000_0000) begin
							rsp_q.sharpe <= 32'sh8000_0000;
							rsp_q.sat    <= 1'b1;
						end else begin
							rsp_q.sharpe <= 32'(-quo_q);
							rsp_q.sat    <= 1'b0;
						end
					end else begin
						if (quo_q > 49'h0_7FFF_FFFF) begin
							rsp_q.sharpe <= 32'sh7FFF_FFFF;
							rsp_q.sat    <= 1'b1;
						end else begin
							rsp_q.sharpe <= quo_q[31:0];
							rsp_q.sat    <= 1'b0;
						end
					end
					mstate_q <= M_IDLE;
				end
				default: mstate_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (mstate_q)
			M_IDLE: begin
				x_q    <= req.variance;
				rem_q  <= '0;
				root_q <= '0;
				neg_q  <= req.excess[32];
				num_q  <= {ex_mag, 16'd0};
				drem_q <= '0;
				quo_q  <= '0;
			end
			M_SQRT: begin
				// one result bit per cycle, two radicand bits in
				x_q <= {x_q[45:0], 2'b00};
				if (sq_ge) begin
					rem_q  <= sq_diff[25:0];
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= sq_sh[25:0];
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			M_DIV: begin
				if (root_q != '0) begin
					num_q  <= {num_q[47:0], 1'b0};
					drem_q <= dv_ge ? dv_diff[24:0] : dv_sh[24:0];
					quo_q  <= {quo_q[47:0], dv_ge};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[tb/sv/portfolio_risk_metrics_tb.sv]
module portfolio_risk_metrics_tb;
	import prm_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int NA = 32;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]         opcode;
		logic [4:0]         asset_index;
		logic [4:0]         peer_index;
		logic [15:0]        weight;
		logic [31:0]        price;
		logic signed [23:0] expected_return;
		logic [23:0]        risk;
		logic signed [15:0] correlation;
	} order_t;

	typedef struct {
		logic signed [31:0] portfolio_return;
		logic [39:0]        weighted_price;
		logic [47:0]        variance;
		logic [23:0]        volatility;
		logic signed [31:0] sharpe_ratio;
		logic               sharpe_undefined;
		logic               saturated;
	} metrics_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [23:0] cfg_data;

	prm_in_if  in_ch ();
	prm_out_if out_ch ();

	portfolio_risk_metrics dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block's state
	logic [15:0]        w_mem [NA];
	logic [31:0]        p_mem [NA];
	logic signed [23:0] r_mem [NA];
	logic [23:0]        s_mem [NA];
	logic signed [15:0] c_mem [NA][NA];
	bit                 asset_ok [NA];
	bit                 corr_ok [NA][NA];
	logic [5:0]         count_cfg;
	logic signed [23:0] rate_cfg;

	metrics_t pending_metrics[$];
	int errors;
	int sent_words;
	longint cycles;
	bit stall_free;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("portfolio_risk_metrics: mismatch");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("error at %0t: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic metrics_t risk_metrics();
		metrics_t m;
		int n;
		longint rsum, ret, acc, prod, term, excess, sh;
		longint unsigned wsum, wp, vr, vol;
		longint av [NA];
		bit sat;
		n = (count_cfg > NA) ? NA : count_cfg;
		rsum = 0; wsum = 0; acc = 0; sat = 0;
		for (int i = 0; i < n; i++) begin
			rsum += longint'(w_mem[i]) * longint'(r_mem[i]);
			wsum += longint'(w_mem[i]) * longint'(p_mem[i]);
			av[i] = (longint'(w_mem[i]) * longint'(s_mem[i])) >>> 16;
		end
		ret = rsum >>> 16;
		if (ret > 64'sd2147483647) begin ret = 64'sd2147483647; sat = 1; end
		if (ret < -64'sd2147483648) begin ret = -64'sd2147483648; sat = 1; end
		wp = wsum >> 16;
		if (wp > 64'hFF_FFFF_FFFF) begin wp = 64'hFF_FFFF_FFFF; sat = 1; end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				prod = av[i] * av[j];
				term = (i == j) ? prod : (prod * longint'(c_mem[i][j])) >>> 15;
				acc += term;
				if (acc > (64'sd1 <<< 62)) acc = 64'sd1 <<< 62;
				if (acc < -(64'sd1 <<< 62)) acc = -(64'sd1 <<< 62);
			end
		if (acc < 0) begin
			vr = 0; sat = 1;
		end else if (acc > 64'sh0000_FFFF_FFFF_FFFF) begin
			vr = 64'h0000_FFFF_FFFF_FFFF; sat = 1;
		end else begin
			vr = acc;
		end
		vol = int_sqrt(vr);
		m.sharpe_undefined = (vol == 0);
		sh = 0;
		if (vol != 0) begin
			excess = ret - longint'(rate_cfg);
			sh = (excess * 65536) / longint'(vol);
			if (sh > 64'sd2147483647) begin sh = 64'sd2147483647; sat = 1; end
			if (sh < -64'sd2147483648) begin sh = -64'sd2147483648; sat = 1; end
		end
		m.portfolio_return = ret[31:0];
		m.weighted_price = wp[39:0];
		m.variance = vr[47:0];
		m.volatility = vol[23:0];
		m.sharpe_ratio = sh[31:0];
		m.saturated = sat;
		return m;
	endfunction

	// apply one accepted word to the shadow state
	task automatic absorb(input order_t o);
		case (o.opcode)
			OP_ASSET: begin
				w_mem[o.asset_index] = o.weight;
				p_mem[o.asset_index] = o.price;
				r_mem[o.asset_index] = o.expected_return;
				s_mem[o.asset_index] = o.risk;
				asset_ok[o.asset_index] = 1;
			end
			OP_CORR: begin
				c_mem[o.asset_index][o.peer_index] = o.correlation;
				corr_ok[o.asset_index][o.peer_index] = 1;
			end
			OP_COMPUTE: pending_metrics.push_back(risk_metrics());
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		if (stall_free) return 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 0;
			5, 6, 7: return $urandom_range(1, 3);
			8: return $urandom_range(4, 8);
			default: return $urandom_range(9, 40);
		endcase
	endfunction

	task automatic send_word(input order_t o);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= o.opcode;
		in_ch.asset_index <= o.asset_index;
		in_ch.peer_index <= o.peer_index;
		in_ch.weight <= o.weight;
		in_ch.price <= o.price;
		in_ch.expected_return <= o.expected_return;
		in_ch.risk <= o.risk;
		in_ch.correlation <= o.correlation;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		absorb(o);
		if (o.opcode != OP_UNUSED) sent_words++;
	endtask

	// hold the sender low and let the block drain before a register write
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait (pending_metrics.size() == 0);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ASSET_COUNT) count_cfg = val[5:0];
		else rate_cfg = val;
	endtask

	function automatic order_t any_word(input logic [1:0] op);
		order_t o;
		o.opcode = op;
		o.asset_index = $urandom_range(0, NA - 1);
		o.peer_index = $urandom_range(0, NA - 1);
		case ($urandom_range(0, 3))
			0: o.weight = 16'hFFFF;
			1: o.weight = $urandom_range(0, 255);
			default: o.weight = $urandom;
		endcase
		o.price = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom;
		o.expected_return = $urandom;
		case ($urandom_range(0, 3))
			0: o.risk = 24'hFF_FFFF;
			1: o.risk = $urandom_range(0, 24'h0F_FFFF);
			default: o.risk = $urandom;
		endcase
		case ($urandom_range(0, 5))
			0: o.correlation = 16'sh7FFF;
			1: o.correlation = -16'sh8000;
			default: o.correlation = $urandom;
		endcase
		return o;
	endfunction

	// load every entry that a compute over n assets will read
	task automatic cover_assets(input int n);
		order_t o;
		for (int i = 0; i < n; i++)
			if (!asset_ok[i]) begin
				o = any_word(OP_ASSET);
				o.asset_index = i;
				send_word(o);
			end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (i != j && !corr_ok[i][j]) begin
					o = any_word(OP_CORR);
					o.asset_index = i;
					o.peer_index = j;
					send_word(o);
				end
	endtask

	always @(posedge clk) begin
		metrics_t exp_m;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_metrics.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				exp_m = pending_metrics.pop_front();
				if (out_ch.portfolio_return !== exp_m.portfolio_return)
					report("portfolio_return", out_ch.portfolio_return, exp_m.portfolio_return);
				if (out_ch.weighted_price !== exp_m.weighted_price)
					report("weighted_price", out_ch.weighted_price, exp_m.weighted_price);
				if (out_ch.variance !== exp_m.variance)
					report("variance", out_ch.variance, exp_m.variance);
				if (out_ch.volatility !== exp_m.volatility)
					report("volatility", out_ch.volatility, exp_m.volatility);
				if (out_ch.sharpe_ratio !== exp_m.sharpe_ratio)
					report("sharpe_ratio", out_ch.sharpe_ratio, exp_m.sharpe_ratio);
				if (out_ch.sharpe_undefined !== exp_m.sharpe_undefined)
					report("sharpe_undefined", out_ch.sharpe_undefined, exp_m.sharpe_undefined);
				if (out_ch.saturated !== exp_m.saturated)
					report("saturated", out_ch.saturated, exp_m.saturated);
			end
		end
	end

	always @(negedge clk) begin
		int hold;
		if (stall_free) begin
			out_ch.ready <= 1'b1;
		end else begin
			hold = $urandom_range(0, 19);
			out_ch.ready <= (hold < 12) || (hold == 19 && $urandom_range(0, 1));
		end
	end

	task automatic test_directed();
		order_t o;
		write_reg(CFG_ASSET_COUNT, 24'd1);
		write_reg(CFG_RISK_FREE, 24'd0);
		o = any_word(OP_ASSET);
		o.asset_index = 0; o.weight = 16'hFFFF; o.price = 32'hFFFF_FFFF;
		o.expected_return = 24'sh7F_FFFF; o.risk = 24'hFF_FFFF;
		send_word(o);
		o.opcode = OP_COMPUTE;
		send_word(o);
		o = any_word(OP_ASSET);
		o.asset_index = 1; o.weight = 16'h0000; o.price = 32'd0;
		o.expected_return = -24'sh80_0000; o.risk = 24'd0;
		send_word(o);
		o = any_word(OP_CORR);
		o.asset_index = 0; o.peer_index = 1; o.correlation = -16'sh8000;
		send_word(o);
		o.asset_index = 1; o.peer_index = 0; o.correlation = 16'sh7FFF;
		send_word(o);
		// diagonal is stored but its value is never used
		o.asset_index = 0; o.peer_index = 0; o.correlation = -16'sh8000;
		send_word(o);
		o.opcode = OP_UNUSED;
		send_word(o);
		settle();
		write_reg(CFG_ASSET_COUNT, 24'd2);
		write_reg(CFG_RISK_FREE, 24'h7F_FFFF);
		o.opcode = OP_COMPUTE;
		send_word(o);
		o = any_word(OP_ASSET);
		o.asset_index = 1; o.weight = 16'hFFFF; o.expected_return = -24'sh80_0000;
		o.risk = 24'hFF_FFFF;
		send_word(o);
		o.opcode = OP_COMPUTE;
		send_word(o);
		o = any_word(OP_CORR);
		o.asset_index = 31; o.peer_index = 31;
		send_word(o);
		o = any_word(OP_ASSET);
		o.asset_index = 31;
		send_word(o);
		settle();
		write_reg(CFG_ASSET_COUNT, 24'd0);
		write_reg(CFG_RISK_FREE, 24'h80_0000);
		o.opcode = OP_COMPUTE;
		send_word(o);
		settle();
	endtask

	task automatic test_count_extremes();
		order_t o;
		cover_assets(NA);
		settle();
		write_reg(CFG_ASSET_COUNT, 24'd32);
		o = any_word(OP_COMPUTE);
		send_word(o);
		settle();
		write_reg(CFG_ASSET_COUNT, 24'd63);
		write_reg(CFG_RISK_FREE, 24'h80_0000);
		send_word(o);
		settle();
	endtask

	task automatic test_random();
		order_t o;
		int n, k;
		while (sent_words < 540) begin
			case ($urandom_range(0, 9))
				0: n = 0;
				1: n = $urandom_range(32, 63);
				2: n = $urandom_range(9, 31);
				default: n = $urandom_range(1, 8);
			endcase
			stall_free = ($urandom_range(0, 4) == 0);
			write_reg(CFG_ASSET_COUNT, 24'(n));
			write_reg(CFG_RISK_FREE, 24'($urandom));
			k = (n > NA) ? NA : n;
			cover_assets(k);
			repeat ($urandom_range(4, 24)) begin
				case ($urandom_range(0, 11))
					0, 1, 2: o = any_word(OP_ASSET);
					3, 4, 5, 6: o = any_word(OP_CORR);
					7: o = any_word(OP_UNUSED);
					default: o = any_word(OP_COMPUTE);
				endcase
				// keep three in four loads inside the loaded range so that they feed the compute
				if (k > 0 && o.opcode != OP_UNUSED && $urandom_range(0, 3) != 0) begin
					o.asset_index = $urandom_range(0, k - 1);
					o.peer_index = $urandom_range(0, k - 1);
				end
				send_word(o);
			end
			settle();
		end
		stall_free = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ASSET_COUNT;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_ASSET;
		in_ch.asset_index = '0;
		in_ch.peer_index = '0;
		in_ch.weight = '0;
		in_ch.price = '0;
		in_ch.expected_return = '0;
		in_ch.risk = '0;
		in_ch.correlation = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		sent_words = 0;
		cycles = 0;
		stall_free = 0;
		count_cfg = 6'd32;
		rate_cfg = '0;
		foreach (asset_ok[i]) asset_ok[i] = 0;
		foreach (corr_ok[i, j]) corr_ok[i][j] = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random();
		test_count_extremes();

		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait (pending_metrics.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("portfolio_risk_metrics: match");
		else
			$display("portfolio_risk_metrics: mismatch");
		$finish;
	end

endmodule

[sim.f]
rtl/prm_pkg.sv
rtl/prm_in_if.sv
rtl/prm_out_if.sv
rtl/prm_math.sv
rtl/portfolio_risk_metrics.sv
tb/sv/portfolio_risk_metrics_tb.sv
